// File: design/lff_pkg.sv
`timescale 1ns / 1ps

package lff_pkg;

	// Field widths of the item channels.
	localparam int SLOT_W  = 4;
	localparam int ROLL_W  = 7;
	localparam int SEG_W   = 6;
	localparam int LED_W   = 4;
	localparam int LEVEL_W = 13;
	localparam int STEP_W  = 8;
	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPAWN_PERCENT = 2'd0,
		REG_FADE_PERCENT  = 2'd1,
		REG_FIRST_COLOR   = 2'd2,
		REG_SECOND_COLOR  = 2'd3
	} cfg_reg_t;

	localparam logic [ROLL_W-1:0]  SPAWN_PERCENT_RST = 7'd2;
	localparam logic [ROLL_W-1:0]  FADE_PERCENT_RST  = 7'd5;
	localparam logic [COLOR_W-1:0] FIRST_COLOR_RST   = 24'hFFFF00;
	localparam logic [COLOR_W-1:0] SECOND_COLOR_RST  = 24'hADFF2F;

	// Brightness scale: 5000 is full on.
	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 13'd5000;
	localparam logic [LEVEL_W-1:0] DRAW_MIN   = 13'd5;
	localparam logic [STEP_W-1:0]  BASE_STEP  = 8'd100;
	localparam logic [13:0]        SMOOTH_BASE = 14'd15000;

	// Divide by 125e9 = 2^9 * 5^12: shift first, then reciprocal with one fix-up.
	localparam int                 DIV_SHIFT   = 9;
	localparam logic [27:0]        DIV_CONST   = 28'd244140625;
	localparam logic [35:0]        DIV_LIMIT   = 36'd488281250;
	localparam logic [16:0]        RECIP       = 17'd72057;
	localparam int                 RECIP_PRE   = 20;

	typedef enum logic [1:0] {
		PH_HIDDEN   = 2'd0,
		PH_FADE_IN  = 2'd1,
		PH_LIT      = 2'd2,
		PH_FADE_OUT = 2'd3
	} fly_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_POLY,
		ST_COLOR,
		ST_EST,
		ST_FIX
	} ctl_state_t;

	typedef struct packed {
		fly_phase_t          phase;
		logic [LEVEL_W-1:0]  level;
		logic [STEP_W-1:0]   step_size;
		logic                hue_choice;
		logic [SEG_W-1:0]    where_segment;
		logic [LED_W-1:0]    where_led;
	} fly_entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [ROLL_W-1:0] spawn_roll;
		logic [ROLL_W-1:0] hold_roll;
		logic [ROLL_W-1:0] speed_roll;
		logic              color_pick;
		logic [SEG_W-1:0]  new_segment;
		logic [LED_W-1:0]  new_led;
	} in_item_t;

	typedef struct packed {
		logic              draw;
		logic [SEG_W-1:0]  pixel_segment;
		logic [LED_W-1:0]  pixel_led;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} out_item_t;

endpackage

// File: design/led_firefly_fader.sv
`timescale 1ns / 1ps
// An accepted item passes the read state and the five-step smoothstep chain (square, polynomial,
// color multiply, reciprocal, fix-up) before its result loads into the output register. The slot
// read-modify-write and that chain share one sequencer, so no new item enters before then.
// The output register lets the next item enter while the last result is still stalled.
// Reset (arst_n low, asynchronous): all slots hidden at zero level, configuration registers at their defaults.
module led_firefly_fader #(
	parameter int FLY_COUNT     = 16,
	parameter int SEGMENT_COUNT = 64,
	parameter int LEDS_PER_SEG  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lff_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lff_pkg::COLOR_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lff_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lff_pkg::out_item_t             out_data
);

	localparam int AW     = (FLY_COUNT > 1) ? $clog2(FLY_COUNT) : 1;
	localparam int SEG_N  = 2 ** lff_pkg::SEG_W;
	localparam int LED_N  = 2 ** lff_pkg::LED_W;

	// Configuration registers.
	logic [lff_pkg::ROLL_W-1:0]  spawn_pct_q;
	logic [lff_pkg::ROLL_W-1:0]  fade_pct_q;
	logic [lff_pkg::COLOR_W-1:0] first_color_q;
	logic [lff_pkg::COLOR_W-1:0] second_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spawn_pct_q    <= lff_pkg::SPAWN_PERCENT_RST;
			fade_pct_q     <= lff_pkg::FADE_PERCENT_RST;
			first_color_q  <= lff_pkg::FIRST_COLOR_RST;
			second_color_q <= lff_pkg::SECOND_COLOR_RST;
		end else if (cfg_we) begin
			unique case (lff_pkg::cfg_reg_t'(cfg_index))
				lff_pkg::REG_SPAWN_PERCENT: spawn_pct_q    <= cfg_data[lff_pkg::ROLL_W-1:0];
				lff_pkg::REG_FADE_PERCENT:  fade_pct_q     <= cfg_data[lff_pkg::ROLL_W-1:0];
				lff_pkg::REG_FIRST_COLOR:   first_color_q  <= cfg_data;
				lff_pkg::REG_SECOND_COLOR:  second_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fold spawn positions into range: constant tables built at elaboration.
	logic [lff_pkg::SEG_W-1:0] seg_fold [SEG_N];
	logic [lff_pkg::LED_W-1:0] led_fold [LED_N];

	for (genvar i = 0; i < SEG_N; i++) begin : g_seg_fold
		localparam logic [lff_pkg::SEG_W-1:0] FOLD = lff_pkg::SEG_W'(i % SEGMENT_COUNT);
		assign seg_fold[i] = FOLD;
	end

	for (genvar i = 0; i < LED_N; i++) begin : g_led_fold
		localparam logic [lff_pkg::LED_W-1:0] FOLD = lff_pkg::LED_W'(i % LEDS_PER_SEG);
		assign led_fold[i] = FOLD;
	end

	// Sequencer.
	lff_pkg::ctl_state_t state_q, state_d;
	logic                mem_re, mem_we, load_out;

	// Held item and slot address.
	lff_pkg::in_item_t in_q;
	logic [AW-1:0]     addr_q;
	logic              range_q;
	logic [11:0]       slot_ext;
	logic [AW-1:0]     rd_addr;
	logic              in_range;

	assign slot_ext = 12'(in_data.slot);
	assign rd_addr  = slot_ext[AW-1:0];
	assign in_range = (32'(in_data.slot) < FLY_COUNT);

	// Slot memory; a valid bit per slot stands for the zero phase and level at reset.
	lff_pkg::fly_entry_t mem [FLY_COUNT];
	lff_pkg::fly_entry_t rd_q;
	lff_pkg::fly_entry_t cur_entry, wr_entry;
	logic [FLY_COUNT-1:0] vld_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= wr_entry;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (mem_re) begin
				vld_rd_q <= in_range ? vld_q[rd_addr] : 1'b0;
			end
		end
	end

	// Slot update: one animation tick of the state machine stored in the entry.
	logic [lff_pkg::LEVEL_W:0] rise_level;

	always_comb begin
		cur_entry = rd_q;
		if (!vld_rd_q) begin
			cur_entry.phase = lff_pkg::PH_HIDDEN;
			cur_entry.level = '0;
		end
		wr_entry   = cur_entry;
		rise_level = {1'b0, cur_entry.level} + (lff_pkg::LEVEL_W + 1)'(cur_entry.step_size);
		unique case (cur_entry.phase)
			lff_pkg::PH_HIDDEN: begin
				if (in_q.spawn_roll < spawn_pct_q) begin
					wr_entry.where_segment = seg_fold[in_q.new_segment];
					wr_entry.where_led     = led_fold[in_q.new_led];
					wr_entry.step_size     = lff_pkg::BASE_STEP + lff_pkg::STEP_W'(in_q.speed_roll);
					wr_entry.hue_choice    = in_q.color_pick;
					wr_entry.level         = '0;
					wr_entry.phase         = lff_pkg::PH_FADE_IN;
				end
			end
			lff_pkg::PH_FADE_IN: begin
				if (rise_level >= (lff_pkg::LEVEL_W + 1)'(lff_pkg::FULL_LEVEL)) begin
					wr_entry.level = lff_pkg::FULL_LEVEL;
					wr_entry.phase = lff_pkg::PH_LIT;
				end else begin
					wr_entry.level = rise_level[lff_pkg::LEVEL_W-1:0];
				end
			end
			lff_pkg::PH_LIT: begin
				if (in_q.hold_roll < fade_pct_q) begin
					wr_entry.phase = lff_pkg::PH_FADE_OUT;
				end
			end
			default: begin
				// Fading out: drop by the step, hide once it would reach zero.
				if (cur_entry.level <= lff_pkg::LEVEL_W'(cur_entry.step_size)) begin
					wr_entry.level = '0;
					wr_entry.phase = lff_pkg::PH_HIDDEN;
				end else begin
					wr_entry.level = cur_entry.level - lff_pkg::LEVEL_W'(cur_entry.step_size);
				end
			end
		endcase
	end

	// Smoothstep datapath registers.
	logic                        draw_s1;
	logic [lff_pkg::LEVEL_W-1:0] lvl_s1;
	logic [lff_pkg::SEG_W-1:0]   seg_s1;
	logic [lff_pkg::LED_W-1:0]   led_s1;
	logic [lff_pkg::COLOR_W-1:0] color_s1;
	logic [25:0]                 lsq_s2;
	logic [13:0]                 tri_s2;
	logic [36:0]                 poly_s3;
	logic [35:0]                 xs_s4 [3];
	logic [7:0]                  qe_s5 [3];
	logic [35:0]                 xs_s5 [3];

	logic [lff_pkg::CHAN_W-1:0]  chan   [3];
	logic [44:0]                 num_c  [3];
	logic [32:0]                 est_c  [3];
	logic [35:0]                 rem_c  [3];
	logic [7:0]                  quo_c  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			chan[k]  = color_s1[(2 - k) * lff_pkg::CHAN_W +: lff_pkg::CHAN_W];
			num_c[k] = 45'(chan[k]) * 45'(poly_s3);
			est_c[k] = 33'(xs_s4[k][35:lff_pkg::RECIP_PRE]) * 33'(lff_pkg::RECIP);
			rem_c[k] = xs_s5[k] - 36'(36'(qe_s5[k]) * 36'(lff_pkg::DIV_CONST));
			quo_c[k] = qe_s5[k] + 8'(rem_c[k] >= 36'(lff_pkg::DIV_CONST));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lff_pkg::ST_IDLE && !in_stall && in_valid) begin
			in_q   <= in_data;
			addr_q <= rd_addr;
		end
		if (state_q == lff_pkg::ST_READ) begin
			// Draw only for a visible slot above the threshold.
			draw_s1  <= range_q && (wr_entry.phase != lff_pkg::PH_HIDDEN)
			            && (wr_entry.level > lff_pkg::DRAW_MIN);
			lvl_s1   <= wr_entry.level;
			seg_s1   <= wr_entry.where_segment;
			led_s1   <= wr_entry.where_led;
			color_s1 <= wr_entry.hue_choice ? first_color_q : second_color_q;
		end
		if (state_q == lff_pkg::ST_SQUARE) begin
			lsq_s2 <= 26'(lvl_s1) * 26'(lvl_s1);
			tri_s2 <= lff_pkg::SMOOTH_BASE - 14'({lvl_s1, 1'b0});
		end
		if (state_q == lff_pkg::ST_POLY) begin
			poly_s3 <= 37'(37'(lsq_s2) * 37'(tri_s2));
		end
		for (int k = 0; k < 3; k++) begin
			if (state_q == lff_pkg::ST_COLOR) begin
				xs_s4[k] <= num_c[k][44:lff_pkg::DIV_SHIFT];
			end
			if (state_q == lff_pkg::ST_EST) begin
				qe_s5[k] <= est_c[k][31:24];
				xs_s5[k] <= xs_s4[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= 1'b0;
		end else if (state_q == lff_pkg::ST_IDLE && in_valid) begin
			range_q <= in_range;
		end
	end

	// Output register.
	logic               out_valid_q;
	lff_pkg::out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (draw_s1) begin
				out_data_q.draw          <= 1'b1;
				out_data_q.pixel_segment <= seg_s1;
				out_data_q.pixel_led     <= led_s1;
				out_data_q.red           <= quo_c[0];
				out_data_q.green         <= quo_c[1];
				out_data_q.blue          <= quo_c[2];
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lff_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			lff_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					mem_re  = 1'b1;
					state_d = lff_pkg::ST_READ;
				end
			end
			lff_pkg::ST_READ: begin
				// Write back the slot; an out-of-range slot leaves memory alone.
				mem_we  = range_q;
				state_d = lff_pkg::ST_SQUARE;
			end
			lff_pkg::ST_SQUARE: state_d = lff_pkg::ST_POLY;
			lff_pkg::ST_POLY:   state_d = lff_pkg::ST_COLOR;
			lff_pkg::ST_COLOR:  state_d = lff_pkg::ST_EST;
			lff_pkg::ST_EST:    state_d = lff_pkg::ST_FIX;
			lff_pkg::ST_FIX: begin
				// Hold until the output register is free or being taken.
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = lff_pkg::ST_IDLE;
				end
			end
			default: state_d = lff_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == lff_pkg::ST_READ))
		else $error("accepted item did not start a slot read");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (wr_entry.level <= lff_pkg::FULL_LEVEL))
		else $error("slot level above full scale");

	// Only a drawing slot carries a color worth dividing; hidden slots may hold stale fields.
	a_quot_fix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lff_pkg::ST_FIX && draw_s1) |-> (rem_c[0] < lff_pkg::DIV_LIMIT)
		&& (rem_c[1] < lff_pkg::DIV_LIMIT) && (rem_c[2] < lff_pkg::DIV_LIMIT))
		else $error("reciprocal estimate off by more than one");

	a_no_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.draw) |-> (out_data_q.pixel_segment == '0)
		&& (out_data_q.pixel_led == '0) && (out_data_q.red == '0)
		&& (out_data_q.green == '0) && (out_data_q.blue == '0))
		else $error("result without draw carries nonzero fields");
`endif

endmodule
